[hw/rtl/bit_field_pack_unpack_buffer_macros.svh]
// Assertion macros for the bit field pack/unpack buffer.
// Included by the RTL file that carries concurrent assertions; needs no package.
`ifndef BIT_FIELD_PACK_UNPACK_BUFFER_MACROS_SVH
`define BIT_FIELD_PACK_UNPACK_BUFFER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BFP_ASSERT(LBL, CK, RN, PROP, MSG) \
    LBL: assert property (@(posedge CK) disable iff (!RN) (PROP)) else $error(MSG);
`define BFP_ASSERT_NEXT(LBL, CK, RN, ANT, CON, MSG) \
    LBL: assert property (@(posedge CK) disable iff (!RN) (ANT) |=> (CON)) else $error(MSG);
`else
`define BFP_ASSERT(LBL, CK, RN, PROP, MSG)
`define BFP_ASSERT_NEXT(LBL, CK, RN, ANT, CON, MSG)
`endif
`endif

[hw/rtl/bfp_pkg.sv]
// Shared types, constants and helper functions for the bit field pack/unpack buffer.
// Has no dependencies; bfp_lane, bfp_merge and the top module import it.
`default_nettype none

package bfp_pkg;

    localparam int HEAD_W = 14;
    localparam int BASE_W = HEAD_W - 3;
    localparam int CNT_W  = 7;
    localparam int DATA_W = 64;
    localparam int IN_W   = 72;
    localparam int OUT_W  = 96;
    localparam logic [HEAD_W-1:0] CAP_RESET = 14'd8192;

    typedef enum logic {
        ST_IDLE,
        ST_RESULT
    } bfp_state_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [BASE_W-1:0] base;
        logic [3:0]        nbytes;
    } lane_ctrl_t;

    typedef struct packed {
        logic [3:0]       base_lo;
        logic [2:0]       off;
        logic [CNT_W-1:0] count;
    } rd_sel_t;

    function automatic logic [DATA_W-1:0] low_mask64(input logic [CNT_W-1:0] n);
        logic [DATA_W-1:0] m;
        if (n >= 7'd64)
        begin
            m = '1;
        end
        else
        begin
            m = (64'd1 << n) - 64'd1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bfp_ram.sv]
// Generic single-port RAM with a registered read, used for every byte bank.
// Has no dependencies.
`default_nettype none

module bfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                        wdata,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/bfp_lane.sv]
// One byte lane: maps the stream byte window onto this bank and holds the bank RAM.
// Depends on bfp_pkg and bfp_ram.
`default_nettype none

module bfp_lane
    import bfp_pkg::*;
#(
    parameter int LANES    = 16,
    parameter int LANE_IDX = 0,
    parameter int LDEPTH   = 64
) (
    input  wire logic                  clk,
    input  wire lane_ctrl_t            ctrl,
    input  wire logic [LANES-1:0][7:0] wbytes,
    output logic      [7:0]            rdata
);

    localparam int LANE_W = $clog2(LANES);
    localparam int AW     = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
    localparam int SUM_W  = (AW + LANE_W > BASE_W + 1) ? AW + LANE_W : BASE_W + 1;
    localparam logic [LANE_W-1:0] LID = LANE_W'(LANE_IDX);

    logic [LANE_W-1:0] slot;
    logic [SUM_W-1:0]  byte_idx;
    logic [AW-1:0]     addr;
    logic              we;

    // The slot is this lane's position inside the window that starts at the base byte.
    assign slot     = LID - ctrl.base[LANE_W-1:0];
    assign byte_idx = SUM_W'(ctrl.base) + SUM_W'(slot);
    assign addr     = AW'(byte_idx >> LANE_W);
    assign we       = ctrl.wr_en && (4'(slot) < ctrl.nbytes);

    bfp_ram #(
        .WIDTH (8),
        .DEPTH (LDEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .re    (ctrl.rd_en),
        .addr  (addr),
        .wdata (wbytes[slot]),
        .rdata (rdata)
    );

endmodule

`default_nettype wire

[hw/rtl/bfp_merge.sv]
// Merge stage: rotates the lane bytes into stream order, aligns and masks the field.
// Depends on bfp_pkg.
`default_nettype none

module bfp_merge
    import bfp_pkg::*;
#(
    parameter int LANES          = 16,
    parameter int MAX_FIELD_BITS = 64
) (
    input  wire rd_sel_t                 sel,
    input  wire logic [LANES-1:0][7:0]   lane_rd,
    output logic [MAX_FIELD_BITS-1:0]    value
);

    localparam int LANE_W = $clog2(LANES);
    localparam int CW     = LANES * 8;

    logic [2*CW-1:0]     rotated;
    logic [CW-1:0]       aligned;
    logic [DATA_W-1:0]   mask;

    always_comb
    begin
        rotated = {lane_rd, lane_rd} >> {sel.base_lo[LANE_W-1:0], 3'b000};
        aligned = rotated[CW-1:0] >> sel.off;
        mask    = low_mask64(sel.count);
        value   = aligned[MAX_FIELD_BITS-1:0] & mask[MAX_FIELD_BITS-1:0];
    end

endmodule

`default_nettype wire

[hw/rtl/bit_field_pack_unpack_buffer.sv]
// The decision, the bank writes and the bank reads happen in the accept cycle; the merge
// stage then loads the output register once it is free or being taken, which can stall.
// No new beat is taken until the previous result has been loaded; a result
// waiting in the output register does not stop the next beat from being accepted.
// Reset (rst_n low, asynchronous) clears both heads, sets the integrity flag and
// sets the capacity to 8192 bits; the byte banks are not cleared.
`default_nettype none

`include "bit_field_pack_unpack_buffer_macros.svh"

module bit_field_pack_unpack_buffer
    import bfp_pkg::*;
#(
    parameter int BUFFER_BYTES   = 1024,
    parameter int MAX_FIELD_BITS = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [HEAD_W-1:0] cfg_data,     // capacity_bits
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,      // field_data[63:0], bit_count[70:64], pad
    input  wire logic              s_tuser,      // command
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata       // read_value, accepted, integrity_ok,
                                                 // bits_written, bits_consumed, pad
);

    localparam int SPAN   = (MAX_FIELD_BITS + 14) / 8;
    localparam int LANE_W = (SPAN > 1) ? $clog2(SPAN) : 1;
    localparam int LANES  = 1 << LANE_W;
    localparam int CW     = LANES * 8;
    localparam int LDEPTH = (BUFFER_BYTES + LANES - 1) / LANES;
    localparam int TOP    = BUFFER_BYTES * 8;

    bfp_state_t state_reg, state_next;

    logic [HEAD_W-1:0] cap_reg, cap_next;
    logic [HEAD_W-1:0] wh_reg, wh_next;
    logic [HEAD_W-1:0] rh_reg, rh_next;
    logic              integ_reg, integ_next;
    logic [7:0]        tail_reg, tail_next;
    logic              cmd_reg, cmd_next;
    logic              ok_reg, ok_next;
    rd_sel_t           sel_reg, sel_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;

    logic                       accept;
    logic                       load;
    logic                       cmd;
    logic [DATA_W-1:0]          data;
    logic [CNT_W-1:0]           cnt;
    logic                       cnt_zero;
    logic                       cnt_big;
    logic [HEAD_W-1:0]          cap_use;
    logic [HEAD_W:0]            wr_sum;
    logic [HEAD_W:0]            rd_sum;
    logic                       wr_fit;
    logic                       rd_fit;
    logic                       do_wr;
    logic                       do_rd;
    logic [2:0]                 off;
    logic [DATA_W-1:0]          dmask;
    logic [MAX_FIELD_BITS-1:0]  data_m;
    logic [LANES-1:0][7:0]      comb_bytes;
    logic [LANE_W-1:0]          tail_slot;
    logic [7:0]                 nb_sum;
    lane_ctrl_t                 lane_ctrl;
    logic [LANES-1:0][7:0]      lane_rd;
    logic [MAX_FIELD_BITS-1:0]  merged;
    logic [DATA_W-1:0]          read_value;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        accept   = s_tvalid && s_tready;
        cmd      = s_tuser;
        data     = s_tdata[DATA_W-1:0];
        cnt      = s_tdata[DATA_W+CNT_W-1:DATA_W];
        cnt_zero = (cnt == '0);
        cnt_big  = (32'(cnt) > MAX_FIELD_BITS);
        cap_use  = (32'(cap_reg) > TOP) ? HEAD_W'(TOP) : cap_reg;
        wr_sum   = {1'b0, wh_reg} + (HEAD_W + 1)'(cnt);
        rd_sum   = {1'b0, rh_reg} + (HEAD_W + 1)'(cnt);
        wr_fit   = (wr_sum <= {1'b0, cap_use});
        rd_fit   = (rd_sum <= {1'b0, wh_reg});
        do_wr    = accept && !cmd && !cnt_zero && !cnt_big && wr_fit;
        do_rd    = accept && cmd && !cnt_zero && !cnt_big && rd_fit;

        off        = cmd ? rh_reg[2:0] : wh_reg[2:0];
        dmask      = low_mask64(cnt);
        data_m     = data[MAX_FIELD_BITS-1:0] & dmask[MAX_FIELD_BITS-1:0];
        comb_bytes = (CW'(data_m) << wh_reg[2:0])
                   | CW'(tail_reg & (8'hff >> (4'd8 - {1'b0, wh_reg[2:0]})));
        tail_slot  = LANE_W'(wr_sum[HEAD_W-1:3] - wh_reg[HEAD_W-1:3]);
        nb_sum     = {5'b0, wh_reg[2:0]} + {1'b0, cnt} + 8'd7;

        lane_ctrl.wr_en  = do_wr;
        lane_ctrl.rd_en  = accept;
        lane_ctrl.base   = cmd ? rh_reg[HEAD_W-1:3] : wh_reg[HEAD_W-1:3];
        lane_ctrl.nbytes = nb_sum[6:3];
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        bfp_lane #(
            .LANES    (LANES),
            .LANE_IDX (g),
            .LDEPTH   (LDEPTH)
        ) u_lane (
            .clk    (clk),
            .ctrl   (lane_ctrl),
            .wbytes (comb_bytes),
            .rdata  (lane_rd[g])
        );
    end

    bfp_merge #(
        .LANES          (LANES),
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_merge (
        .sel     (sel_reg),
        .lane_rd (lane_rd),
        .value   (merged)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_RESULT:
            begin
                load = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cap_next   = (cfg_valid && cfg_ready) ? cfg_data : cap_reg;
        wh_next    = do_wr ? wr_sum[HEAD_W-1:0] : wh_reg;
        rh_next    = do_rd ? rd_sum[HEAD_W-1:0] : rh_reg;
        integ_next = integ_reg;
        if (accept && cmd && !cnt_zero && !cnt_big && !rd_fit)
        begin
            integ_next = 1'b0;
        end
        tail_next = do_wr ? comb_bytes[tail_slot] : tail_reg;

        cmd_next = cmd_reg;
        ok_next  = ok_reg;
        sel_next = sel_reg;
        if (accept)
        begin
            cmd_next       = cmd;
            ok_next        = cnt_zero || (!cnt_big && (cmd ? rd_fit : wr_fit));
            sel_next.base_lo = 4'(rh_reg[LANE_W+2:3]);
            sel_next.off   = off;
            sel_next.count = cnt;
        end

        read_value = (cmd_reg && ok_reg) ? DATA_W'(merged) : '0;

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {2'b00, rh_reg, wh_reg, integ_reg, ok_reg, read_value};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            wh_reg        <= '0;
            rh_reg        <= '0;
            integ_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            wh_reg        <= wh_next;
            rh_reg        <= rh_next;
            integ_reg     <= integ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg     <= tail_next;
        cmd_reg      <= cmd_next;
        ok_reg       <= ok_next;
        sel_reg      <= sel_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `BFP_ASSERT(a_heads_order, clk, rst_n, rh_reg <= wh_reg, "read head passed write head")
    `BFP_ASSERT(a_head_top, clk, rst_n, 32'(wh_reg) <= TOP, "write head beyond buffer")
    `BFP_ASSERT_NEXT(a_integ_sticky, clk, rst_n, !integ_reg, !integ_reg, "integrity flag set again")
    `BFP_ASSERT_NEXT(a_accept_busy, clk, rst_n, s_tvalid && s_tready, !s_tready, "beat accepted while busy")

endmodule

`default_nettype wire
